// File: rtl/tfpid_pkg.sv
// ----------------------------------------------------------------------------
// tfpid_pkg
// Shared types, register indexes and the sensor-to-error table of the tape
// follower PID unit.
// ----------------------------------------------------------------------------
package tfpid_pkg;

   localparam int unsigned GainWidth  = 16;
   localparam int unsigned LimitWidth = 23;
   localparam int unsigned ErrWidth   = 4;
   localparam int unsigned IntegWidth = 24;
   localparam int unsigned DriveWidth = 25;
   localparam int unsigned TermWidth  = 22;

   typedef logic [GainWidth-1:0]         gain_type;
   typedef logic [LimitWidth-1:0]        limit_type;
   typedef logic signed [ErrWidth-1:0]   err_type;
   typedef logic signed [IntegWidth-1:0] integ_type;
   typedef logic signed [DriveWidth-1:0] drive_type;
   typedef logic signed [TermWidth-1:0]  term_type;

   typedef enum logic [1:0] {
      CSR_GAIN_PROP   = 2'd0,
      CSR_GAIN_INTEG  = 2'd1,
      CSR_GAIN_DERIV  = 2'd2,
      CSR_INTEG_LIMIT = 2'd3
   } csr_index_type;

   localparam gain_type  GAIN_PROP_RESET   = 16'd5888;
   localparam gain_type  GAIN_INTEG_RESET  = 16'd0;
   localparam gain_type  GAIN_DERIV_RESET  = 16'd3840;
   localparam limit_type INTEG_LIMIT_RESET = 23'd25600;

   localparam err_type ERR_LEFT_MID   = -4'sd1;
   localparam err_type ERR_MID_RIGHT  = 4'sd1;
   localparam err_type ERR_CENTER     = 4'sd0;
   localparam err_type ERR_RIGHT_ONLY = -4'sd2;
   localparam err_type ERR_LOST_LEFT  = 4'sd5;
   localparam err_type ERR_LEFT_ONLY  = 4'sd2;
   localparam err_type ERR_LOST_RIGHT = -4'sd5;

   typedef struct packed {
      logic left;
      logic mid;
      logic right;
   } sense_type;

   function automatic err_type pick_error(input sense_type s, input logic last_left,
                                          input logic last_right, input err_type last_err);
      err_type e;
      if (s.left && s.mid) begin
         e = ERR_LEFT_MID;
      end else if (s.mid && s.right) begin
         e = ERR_MID_RIGHT;
      end else if (s.mid) begin
         e = ERR_CENTER;
      end else if (!s.left && s.right) begin
         e = ERR_RIGHT_ONLY;
      end else if (!s.left && !s.right && last_left) begin
         e = ERR_LOST_LEFT;
      end else if (s.left && !s.right) begin
         e = ERR_LEFT_ONLY;
      end else if (!s.left && !s.right && last_right) begin
         e = ERR_LOST_RIGHT;
      end else begin
         e = last_err;
      end
      return e;
   endfunction

endpackage

// File: rtl/tape_follow_pid_unit.sv
// ----------------------------------------------------------------------------
// tape_follow_pid_unit
// PID steering for a three-sensor tape follower: sensor sample in, drive
// change and tracking error out.
// ----------------------------------------------------------------------------
// The unit takes one sensor sample per clock while the output side is ready
// and returns one result per sample, in order. A sample is captured in an
// input register; when the result register is empty or draining, the error
// lookup, the three gain products, the clamped integral and the final sum are
// formed in one pass and land in the result register, where the result is
// presented and can be taken at the following edge when the output side is
// ready. Throughput is one item per cycle while the output is not stalled;
// the same pass also updates the error, side and integral history. A stalled
// result holds the result register and any item waiting in the input register;
// an empty input register still takes an item, and a full one takes the next
// item in the cycle it drains into an empty or draining result register.
module tape_follow_pid_unit
   import tfpid_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] sense_left, [1] sense_mid, [2] sense_right, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [24:0] drive_change, [28:25] track_error, zero pad
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [22:0] csr_wdata
);

   gain_type  gain_prop_ff, gain_integ_ff, gain_deriv_ff;
   limit_type integ_limit_ff;

   logic      in_valid_ff, in_valid_in;
   sense_type sense_ff, sense_in;

   err_type   last_err_ff, last_err_in;
   logic      last_left_ff, last_left_in;
   logic      last_right_ff, last_right_in;
   integ_type integ_ff, integ_in;

   logic      out_valid_ff, out_valid_in;
   drive_type drive_ff, drive_in;
   err_type   err_out_ff, err_out_in;

   logic      advance;
   err_type   err;
   logic signed [4:0]            err_diff;
   term_type                     err_ext, diff_ext, p_term, d_term, i_term;
   logic signed [DriveWidth-1:0] integ_sum, lim_pos, lim_neg, integ_clamp;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_prop_ff   <= GAIN_PROP_RESET;
         gain_integ_ff  <= GAIN_INTEG_RESET;
         gain_deriv_ff  <= GAIN_DERIV_RESET;
         integ_limit_ff <= INTEG_LIMIT_RESET;
      end else if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_GAIN_PROP:   gain_prop_ff   <= csr_wdata[GainWidth-1:0];
            CSR_GAIN_INTEG:  gain_integ_ff  <= csr_wdata[GainWidth-1:0];
            CSR_GAIN_DERIV:  gain_deriv_ff  <= csr_wdata[GainWidth-1:0];
            CSR_INTEG_LIMIT: integ_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      sense_in    = sense_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         sense_in    = '{left: req_tdata[0], mid: req_tdata[1], right: req_tdata[2]};
      end
   end

   always_comb begin
      err      = pick_error(sense_ff, last_left_ff, last_right_ff, last_err_ff);
      err_diff = {err[ErrWidth-1], err} - {last_err_ff[ErrWidth-1], last_err_ff};
      err_ext  = {{(TermWidth-ErrWidth){err[ErrWidth-1]}}, err};
      diff_ext = {{(TermWidth-5){err_diff[4]}}, err_diff};
      p_term   = term_type'({6'd0, gain_prop_ff}) * err_ext;
      d_term   = term_type'({6'd0, gain_deriv_ff}) * diff_ext;
      i_term   = term_type'({6'd0, gain_integ_ff}) * err_ext;

      integ_sum = {integ_ff[IntegWidth-1], integ_ff}
                + {{(DriveWidth-TermWidth){i_term[TermWidth-1]}}, i_term};
      lim_pos   = {2'b00, integ_limit_ff};
      lim_neg   = -lim_pos;
      if (integ_sum > lim_pos) begin
         integ_clamp = lim_pos;
      end else if (integ_sum < lim_neg) begin
         integ_clamp = lim_neg;
      end else begin
         integ_clamp = integ_sum;
      end

      last_err_in   = last_err_ff;
      last_left_in  = last_left_ff;
      last_right_in = last_right_ff;
      integ_in      = integ_ff;
      drive_in      = drive_ff;
      err_out_in    = err_out_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      if (advance) begin
         last_err_in   = err;
         last_left_in  = sense_ff.left;
         last_right_in = sense_ff.right;
         integ_in      = integ_clamp[IntegWidth-1:0];
         drive_in      = {{(DriveWidth-TermWidth){p_term[TermWidth-1]}}, p_term}
                       + {{(DriveWidth-TermWidth){d_term[TermWidth-1]}}, d_term}
                       + integ_clamp;
         err_out_in    = err;
         out_valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         last_err_ff   <= '0;
         last_left_ff  <= 1'b0;
         last_right_ff <= 1'b0;
         integ_ff      <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         last_err_ff   <= last_err_in;
         last_left_ff  <= last_left_in;
         last_right_ff <= last_right_in;
         integ_ff      <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      sense_ff   <= sense_in;
      drive_ff   <= drive_in;
      err_out_ff <= err_out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'd0, err_out_ff, drive_ff};

   a_integ_bounded: assert property (@(posedge clock) disable iff (reset)
      advance |=> (integ_ff <= $signed({2'b00, integ_limit_ff})
                && integ_ff >= -$signed({2'b00, integ_limit_ff})))
      else $error("integral outside its limit");

   a_err_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (err_out_ff <= 4'sd5 && err_out_ff >= -4'sd5))
      else $error("tracking error out of range");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("advanced item did not reach the result register");

   a_hold_blocks: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |-> !req_tready)
      else $error("item accepted over a held input register");

   a_history: assert property (@(posedge clock) disable iff (reset)
      advance |=> (last_err_ff == err_out_ff))
      else $error("error history does not match delivered error");

endmodule
